[hdl/tas_pkg.sv]
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and codes for the tile animation sequencer.
// ----------------------------------------------------------------------------
package tas_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_LOAD,
    S_RD,
    S_RD_WAIT,
    S_TICK,
    S_T_EVAL,
    S_T_SUCC,
    S_T_DLY
  } state_t;

  // item modes, anything above MODE_TICK is a query
  localparam logic [2:0] MODE_LOAD      = 3'd0;
  localparam logic [2:0] MODE_SET_SUCC  = 3'd1;
  localparam logic [2:0] MODE_SET_DELAY = 3'd2;
  localparam logic [2:0] MODE_TICK      = 3'd3;

endpackage

[hdl/tas_ram.sv]
// ----------------------------------------------------------------------------
// tas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tile_animation_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tile_animation_sequencer_unit
// Per-tile animation tables (successor, delay, shown tile, countdown) with
// load, edit, frame tick and query commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; one result follows,
// shown for a single cycle with done high, and cannot be stalled. All four
// tables share one RAM word per tile behind one read and one write port, and
// a small sequencer does every access in turn. The tile index is first
// reduced modulo MAX_TILES by repeated subtraction in S_REDUCE, which
// repeats once per subtraction while the index is out of range, possible
// only when MAX_TILES is below 256. A load then passes through S_LOAD, an
// edit or query through S_RD and S_RD_WAIT; done follows in the next cycle.
// A frame tick walks tiles 0..min(tile_count, MAX_TILES)-1 through the RAM
// port in S_TICK and S_T_EVAL, adding S_T_SUCC and S_T_DLY for a tile whose
// countdown runs out (it reads the shown tile's successor and then the new
// tile's delay), then reads the addressed tile through S_RD and S_RD_WAIT.
// The tables come out of reset undefined; entries must be loaded first.
module tile_animation_sequencer_unit
  import tas_pkg::*;
#(
  parameter int MAX_TILES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [7:0]         tile,
  input  logic signed [15:0] successor,
  input  logic signed [15:0] frame_delay,
  output logic               done,
  output logic [7:0]         shown_tile,
  output logic signed [15:0] countdown,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);

  typedef struct packed {
    logic [15:0]   succ;
    logic [15:0]   dly;
    logic [AW-1:0] shown;
    logic [15:0]   cd;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t        state, state_next;
  logic [8:0]    tile_count;
  logic [2:0]    mode_r;
  logic [7:0]    tcur;
  logic [AW-1:0] addr;
  logic [15:0]   succ_in;
  logic [15:0]   dly_in;
  logic [CW-1:0] idx;
  entry_t        ent;
  logic [AW-1:0] nt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;
  logic [EW-1:0] rdata;
  entry_t        rd_ent;

  logic [16:0]   live;
  logic          too_big, walk_done, cd_pos, cd_last, succ_ok;
  logic [AW-1:0] nt_c;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign rd_ent    = entry_t'(rdata);

  assign live      = (17'(tile_count) > 17'(MAX_TILES)) ? 17'(MAX_TILES) : 17'(tile_count);
  assign too_big   = (17'(tcur) >= 17'(MAX_TILES));
  assign walk_done = (17'(idx) >= live);
  assign cd_pos    = (rd_ent.cd != 16'd0) && !rd_ent.cd[15];
  assign cd_last   = (rd_ent.cd == 16'd1);
  // successor of the shown tile, valid only inside the live range
  assign succ_ok   = !rd_ent.succ[15] && (17'(rd_ent.succ) < live);
  assign nt_c      = succ_ok ? AW'(rd_ent.succ) : ent.shown;

  tas_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TILES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (!too_big) begin
          priority case (mode_r)
            MODE_LOAD: state_next = S_LOAD;
            MODE_TICK: state_next = S_TICK;
            default:   state_next = S_RD;
          endcase
        end
      end
      S_LOAD:    state_next = S_IDLE;
      S_RD:      state_next = S_RD_WAIT;
      S_RD_WAIT: state_next = S_IDLE;
      S_TICK:    state_next = walk_done ? S_RD : S_T_EVAL;
      S_T_EVAL:  state_next = (cd_pos && cd_last) ? S_T_SUCC : S_TICK;
      S_T_SUCC:  state_next = S_T_DLY;
      S_T_DLY:   state_next = S_TICK;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = addr;
    raddr = addr;
    wdata = ent;
    unique case (state)
      S_LOAD: begin
        we    = 1'b1;
        wdata = '{succ: succ_in, dly: dly_in, shown: addr, cd: dly_in};
      end
      S_RD: begin
        re = 1'b1;
      end
      S_RD_WAIT: begin
        wdata = rd_ent;
        if (mode_r == MODE_SET_SUCC) begin
          we         = 1'b1;
          wdata.succ = succ_in;
        end else if (mode_r == MODE_SET_DELAY) begin
          we        = 1'b1;
          wdata.dly = dly_in;
        end
      end
      S_TICK: begin
        re    = !walk_done;
        raddr = idx[AW-1:0];
      end
      S_T_EVAL: begin
        waddr = idx[AW-1:0];
        raddr = rd_ent.shown;
        wdata = rd_ent;
        if (cd_pos && cd_last) begin
          re = 1'b1;
        end else if (cd_pos) begin
          we       = 1'b1;
          wdata.cd = rd_ent.cd - 16'd1;
        end
      end
      S_T_SUCC: begin
        re    = 1'b1;
        raddr = nt_c;
      end
      S_T_DLY: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = '{succ: ent.succ, dly: ent.dly, shown: nt, cd: rd_ent.dly};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tile_count <= 9'd0;
      done       <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_LOAD) || (state == S_RD_WAIT);
      if (cfg_valid && cfg_ready) begin
        tile_count <= cfg_data;
      end
      unique case (state)
        S_REDUCE: begin
          idx <= '0;
        end
        S_T_EVAL: begin
          if (!(cd_pos && cd_last)) idx <= idx + CW'(1);
        end
        S_T_DLY: begin
          idx <= idx + CW'(1);
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          mode_r  <= mode;
          tcur    <= tile;
          succ_in <= successor;
          dly_in  <= frame_delay;
        end
      end
      S_REDUCE: begin
        // tile index modulo MAX_TILES, one subtraction a cycle
        if (too_big) tcur <= tcur - 8'(MAX_TILES);
        else         addr <= AW'(tcur);
      end
      S_LOAD: begin
        shown_tile <= 8'(addr);
        countdown  <= dly_in;
      end
      S_RD_WAIT: begin
        shown_tile <= 8'(rd_ent.shown);
        countdown  <= rd_ent.cd;
      end
      S_T_EVAL: begin
        ent <= rd_ent;
      end
      S_T_SUCC: begin
        nt <= nt_c;
      end
      default: begin
        nt <= nt;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_EVAL || state == S_T_DLY) |-> (17'(idx) < live))
    else $error("tick walk beyond live tile count");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("table write while idle");
`endif

endmodule

[verif/tile_animation_sequencer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_animation_sequencer_unit_test
// Self-checking bench for the tile animation sequencer: a directed table of
// loads, edits, ticks and queries, then random phases at several tile counts,
// each answer checked against typed row values or an in-bench table model.
// ----------------------------------------------------------------------------
module tile_animation_sequencer_unit_test;
  import tas_pkg::*;

  localparam logic [2:0] MODE_QUERY  = 3'd4;
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int         TABLE_DEPTH = 256;
  localparam int         STALL_LIMIT = 20000;
  localparam int         PHASE_ITEMS = 45;

  typedef struct packed {
    logic [7:0]  shown;
    logic [15:0] cd;
  } frame_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  tile;
    logic [15:0] succ;
    logic [15:0] dly;
    logic        typed;
    logic [7:0]  exp_shown;
    logic [15:0] exp_cd;
  } op_row_t;

  // tile count is 4 while this table runs
  localparam op_row_t DIRECTED_ROWS[19] = '{
    '{MODE_LOAD,      8'd0,   16'd1,      16'd2,      1'b1, 8'd0,   16'd2},
    '{MODE_LOAD,      8'd1,   16'd0,      16'd1,      1'b1, 8'd1,   16'd1},
    '{MODE_LOAD,      8'd2,   16'h8000,   16'h7fff,   1'b1, 8'd2,   16'h7fff},
    '{MODE_LOAD,      8'd3,   16'd4,      16'd1,      1'b1, 8'd3,   16'd1},
    '{MODE_LOAD,      8'd255, 16'h7fff,   16'h8000,   1'b1, 8'd255, 16'h8000},
    '{MODE_QUERY,     8'd0,   16'd0,      16'd0,      1'b1, 8'd0,   16'd2},
    '{MODE_TICK,      8'd0,   16'd0,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_TICK,      8'd1,   16'hffff,   16'hffff,   1'b0, 8'd0,   16'd0},
    '{MODE_SET_SUCC,  8'd3,   16'd2,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_SET_DELAY, 8'd2,   16'd0,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_LOAD,      8'd2,   16'd0,      16'd0,      1'b1, 8'd2,   16'd0},
    '{MODE_LOAD,      8'd1,   16'd1,      16'hffff,   1'b1, 8'd1,   16'hffff},
    '{MODE_TICK,      8'd3,   16'd0,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_SPARE5,    8'd0,   16'hffff,   16'hffff,   1'b0, 8'd0,   16'd0},
    '{MODE_SPARE6,    8'd1,   16'd0,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_SPARE7,    8'd2,   16'd0,      16'd0,      1'b0, 8'd0,   16'd0},
    '{MODE_TICK,      8'd255, 16'd0,      16'd0,      1'b1, 8'd255, 16'h8000},
    '{MODE_SET_SUCC,  8'd255, 16'hffff,   16'd0,      1'b1, 8'd255, 16'h8000},
    '{MODE_SET_DELAY, 8'd255, 16'd0,      16'd12345,  1'b1, 8'd255, 16'h8000}
  };

  localparam int PHASE_COUNTS[9] = '{0, 3, 1, 16, 2, 256, 37, 255, 5};
  localparam int IDLE_PCT[4]     = '{0, 45, 0, 26};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         mode = '0;
  logic [7:0]         tile = '0;
  logic signed [15:0] successor = '0;
  logic signed [15:0] frame_delay = '0;
  logic               done;
  logic [7:0]         shown_tile;
  logic signed [15:0] countdown;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [8:0]         cfg_data = '0;

  // model of the animation tables
  logic [15:0] succ_tbl [TABLE_DEPTH];
  logic [15:0] delay_tbl [TABLE_DEPTH];
  logic [7:0]  shown_tbl [TABLE_DEPTH];
  logic [15:0] cd_tbl [TABLE_DEPTH];
  logic [8:0]  tiles_in_use = '0;
  bit          loaded [TABLE_DEPTH];
  int          loaded_tiles[$];

  frame_state_t pending_frames[$];
  int           fail_count = 0;
  int           stall_cycles = 0;
  int           idle_pct = 0;

  tile_animation_sequencer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .tile        (tile),
    .successor   (successor),
    .frame_delay (frame_delay),
    .done        (done),
    .shown_tile  (shown_tile),
    .countdown   (countdown),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int live_tiles();
    return (tiles_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(tiles_in_use);
  endfunction

  function automatic void advance_frame();
    int n;
    int nxt;
    logic [15:0] s;
    n = live_tiles();
    for (int i = 0; i < n; i++) begin
      if ($signed(cd_tbl[i]) > 0) begin
        cd_tbl[i] = cd_tbl[i] - 16'd1;
        if (cd_tbl[i] == 16'd0) begin
          nxt = shown_tbl[i];
          s = succ_tbl[nxt];
          // an out-of-range successor holds the tile but still reloads
          if (!s[15] && int'(s) < n) nxt = int'(s);
          shown_tbl[i] = nxt[7:0];
          cd_tbl[i] = delay_tbl[nxt];
        end
      end
    end
  endfunction

  function automatic frame_state_t apply_command(logic [2:0] m, logic [7:0] t,
                                                 logic [15:0] s, logic [15:0] d);
    frame_state_t r;
    case (m)
      MODE_LOAD: begin
        succ_tbl[t]  = s;
        delay_tbl[t] = d;
        shown_tbl[t] = t;
        cd_tbl[t]    = d;
        if (!loaded[t]) begin
          loaded[t] = 1'b1;
          loaded_tiles.push_back(int'(t));
        end
      end
      MODE_SET_SUCC:  succ_tbl[t] = s;
      MODE_SET_DELAY: delay_tbl[t] = d;
      MODE_TICK:      advance_frame();
      default: ;
    endcase
    r.shown = shown_tbl[t];
    r.cd    = cd_tbl[t];
    return r;
  endfunction

  task automatic issue_command(logic [2:0] m, logic [7:0] t, logic [15:0] s,
                               logic [15:0] d, bit typed, frame_state_t typed_frame);
    frame_state_t predicted;
    start       <= 1'b1;
    mode        <= m;
    tile        <= t;
    successor   <= s;
    frame_delay <= d;
    do @(posedge clk); while (busy);
    predicted = apply_command(m, t, s, d);
    pending_frames.push_back(typed ? typed_frame : predicted);
    // random sender gaps
    if (($urandom_range(0, 99) < idle_pct)) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic write_tile_count(logic [8:0] value);
    start     <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    tiles_in_use = value;
  endtask

  task automatic random_command();
    int n;
    int first_gap;
    int pick;
    logic [2:0] m;
    logic [7:0] t;
    logic [15:0] s;
    logic [15:0] d;
    n = live_tiles();
    first_gap = -1;
    for (int i = 0; i < n; i++) begin
      if (!loaded[i] && first_gap < 0) first_gap = i;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) s = 16'($urandom_range(0, (n > 0) ? n - 1 : 0));
    else           s = 16'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60)      d = 16'($urandom_range(1, 3));
    else if (pick < 70) d = 16'd0;
    else if (pick < 80) d = 16'($urandom()) | 16'h8000;
    else if (pick < 95) d = 16'($urandom_range(4, 40));
    else                d = 16'($urandom());
    t = 8'(loaded_tiles[$urandom_range(0, loaded_tiles.size() - 1)]);
    pick = $urandom_range(0, 99);
    if (first_gap >= 0) begin
      // every tile a tick walks must hold a loaded entry
      m = MODE_LOAD;
      t = 8'(first_gap);
    end else if (pick < 15) begin
      m = MODE_LOAD;
      if ($urandom_range(0, 9) < 7 && n > 0) t = 8'($urandom_range(0, n - 1));
      else t = 8'($urandom());
    end else if (pick < 30) begin
      m = MODE_SET_SUCC;
    end else if (pick < 45) begin
      m = MODE_SET_DELAY;
    end else if (pick < 78) begin
      m = MODE_TICK;
    end else begin
      m = 3'($urandom_range(MODE_QUERY, MODE_SPARE7));
    end
    issue_command(m, t, s, d, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    frame_state_t want;
    if (!rst && done) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: shown_tile %0d countdown %0d", shown_tile, countdown);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (shown_tile !== want.shown) begin
          $error("shown_tile: expected %0d, got %0d", want.shown, shown_tile);
          fail_count++;
        end
        if (countdown !== want.cd) begin
          $error("countdown: expected %0d, got %0d", $signed(want.cd), countdown);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    frame_state_t typed_frame;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      succ_tbl[i]  = '0;
      delay_tbl[i] = '0;
      shown_tbl[i] = '0;
      cd_tbl[i]    = '0;
      loaded[i]    = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_tile_count(9'd4);
    foreach (DIRECTED_ROWS[i]) begin
      typed_frame.shown = DIRECTED_ROWS[i].exp_shown;
      typed_frame.cd    = DIRECTED_ROWS[i].exp_cd;
      issue_command(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].tile, DIRECTED_ROWS[i].succ,
                    DIRECTED_ROWS[i].dly, DIRECTED_ROWS[i].typed, typed_frame);
    end

    foreach (PHASE_COUNTS[p]) begin
      write_tile_count(9'(PHASE_COUNTS[p]));
      idle_pct = IDLE_PCT[p % 4];
      for (int k = 0; k < PHASE_ITEMS; k++) random_command();
      // keep going while fewer tiles have been loaded in total than are in use
      while (loaded_tiles.size() < live_tiles()) random_command();
    end

    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
